>>> hdl/ptpf_pkg.sv
// Constants and types shared by the point/triangle projection frame pipeline.
`default_nettype none

package ptpf_pkg;

    // Input coordinate format
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;

    // Result width for ratios and vectors
    localparam int RAT_W = 32;

    // Edge, product and dot widths
    localparam int E_W     = COORD_BITS + 1;
    localparam int PROD1_W = 2 * E_W;
    localparam int DOT_W   = PROD1_W + 2;
    localparam int HALF_W  = DOT_W / 2;
    localparam int HI_W    = DOT_W - HALF_W;
    localparam int PP_W    = DOT_W + 2;
    localparam int PROD2_W = 2 * DOT_W;
    localparam int NUM_W   = PROD2_W + 1;
    localparam int SH_W    = NUM_W + FRAC_BITS;
    localparam int CMP_W   = NUM_W + RAT_W;

    // Frame vector widths
    localparam int VP_W = RAT_W + E_W;
    localparam int VS_W = VP_W + 2;

    // Pipeline depth: six front stages, divider prep, one stage per quotient bit,
    // ratio, vector product and output stages
    localparam int PIPE_DEPTH = 10 + RAT_W;

    // Dot product slots
    localparam int DOT_N = 5;
    localparam int D_00  = 0;
    localparam int D_01  = 1;
    localparam int D_11  = 2;
    localparam int D_B0  = 3;
    localparam int D_B1  = 4;

    // Wide product operand pairs: d00*d11, d01*d01, d11*b0, d01*b1, d00*b1, d01*b0
    localparam int WP_N = 6;
    localparam int WP_A [WP_N] = '{D_00, D_01, D_11, D_01, D_00, D_01};
    localparam int WP_B [WP_N] = '{D_11, D_01, D_B0, D_B1, D_B1, D_B0};

    // Divider lanes
    localparam int LANE_N     = 3;
    localparam int LANE_ALPHA = 0;
    localparam int LANE_BETA  = 1;
    localparam int LANE_GAMMA = 2;

    typedef logic [2:0][E_W-1:0] t_vec;

    typedef struct packed {
        t_vec e0;
        t_vec e1;
        t_vec e2;
    } t_edges;

    typedef struct packed {
        logic [LANE_N-1:0] neg;
        logic [LANE_N-1:0] ovf;
        logic              degen;
    } t_side;

endpackage

`default_nettype wire

>>> hdl/point_triangle_projection_frame_unit.sv
// Point/triangle projection frame: fully pipelined top level.
//
// One query (p0 and triangle p1, p2, p3) can be started every clock; busy is
// always low. Each query returns one beat, marked by o_valid, once it has
// passed all ptpf_pkg::PIPE_DEPTH pipeline stages: the 32 restoring-divider
// stages, one quotient bit each, plus ten arithmetic stages.
// The result must be taken in the cycle it is shown. A degenerate triangle
// (zero e0 or collinear edges) returns all zeros with o_degenerate set.
`default_nettype none

module point_triangle_projection_frame_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p0_x,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p0_y,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p0_z,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p1_x,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p1_y,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p1_z,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p2_x,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p2_y,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p2_z,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p3_x,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p3_y,
    input  wire  [ptpf_pkg::COORD_BITS-1:0]   i_p3_z,
    output logic                              o_valid,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_alpha_ratio,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_beta_coord,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_gamma_coord,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_ortho_edge_x,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_ortho_edge_y,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_ortho_edge_z,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_normal_part_x,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_normal_part_y,
    output logic signed [ptpf_pkg::RAT_W-1:0] o_normal_part_z,
    output logic                              o_degenerate
);

    localparam int RW = ptpf_pkg::RAT_W;
    localparam int DV = ptpf_pkg::RAT_W;   // divider stages
    localparam int PD = ptpf_pkg::PIPE_DEPTH;

    // Valid chain, one bit per stage
    logic r_vld [1:PD];

    // Edges ride along until the output stage
    ptpf_pkg::t_edges r_ed [1:PD-1];

    logic [2:0][ptpf_pkg::COORD_BITS-1:0] w_p0, w_p1, w_p2, w_p3;
    ptpf_pkg::t_edges n_ed;

    logic signed [ptpf_pkg::PROD1_W-1:0] r_mp  [0:ptpf_pkg::DOT_N-1][0:2];
    logic signed [ptpf_pkg::DOT_W-1:0]   r_dot [0:ptpf_pkg::DOT_N-1];

    logic signed [ptpf_pkg::PP_W-1:0]    r_pp_hh [0:ptpf_pkg::WP_N-1];
    logic signed [ptpf_pkg::PP_W-1:0]    r_pp_hl [0:ptpf_pkg::WP_N-1];
    logic signed [ptpf_pkg::PP_W-1:0]    r_pp_lh [0:ptpf_pkg::WP_N-1];
    logic signed [ptpf_pkg::PP_W-1:0]    r_pp_ll [0:ptpf_pkg::WP_N-1];
    logic signed [ptpf_pkg::DOT_W-1:0]   r_an4, r_ad4, r_an5, r_ad5;
    logic signed [ptpf_pkg::PROD2_W-1:0] r_wp [0:ptpf_pkg::WP_N-1];

    logic signed [ptpf_pkg::NUM_W-1:0]   r_num [0:ptpf_pkg::LANE_N-1];
    logic signed [ptpf_pkg::NUM_W-1:0]   r_den [0:ptpf_pkg::LANE_N-1];

    // Divider pipeline: index 0 is the prep stage, index s holds s quotient bits
    logic [ptpf_pkg::SH_W-1:0]  r_rem [0:DV][0:ptpf_pkg::LANE_N-1];
    logic [ptpf_pkg::NUM_W-1:0] r_dm  [0:DV][0:ptpf_pkg::LANE_N-1];
    logic [RW-1:0]              r_q   [0:DV][0:ptpf_pkg::LANE_N-1];
    ptpf_pkg::t_side            r_sd  [0:DV];

    ptpf_pkg::t_side            n_sd;
    logic [ptpf_pkg::SH_W-1:0]  n_rem [0:ptpf_pkg::LANE_N-1];
    logic [ptpf_pkg::NUM_W-1:0] n_dm  [0:ptpf_pkg::LANE_N-1];
    logic [ptpf_pkg::CMP_W-1:0] w_dsub [1:DV][0:ptpf_pkg::LANE_N-1];

    logic signed [RW-1:0] r_rat  [0:ptpf_pkg::LANE_N-1];
    logic signed [RW-1:0] r_rat2 [0:ptpf_pkg::LANE_N-1];
    logic signed [RW-1:0] n_rat  [0:ptpf_pkg::LANE_N-1];
    logic                 r_dg_r, r_dg_p;

    logic signed [ptpf_pkg::VP_W-1:0] r_pa [0:2];
    logic signed [ptpf_pkg::VP_W-1:0] r_pb [0:2];
    logic signed [ptpf_pkg::VP_W-1:0] r_pg [0:2];

    logic signed [RW-1:0] n_ortho [0:2];
    logic signed [RW-1:0] n_norm  [0:2];
    logic signed [RW-1:0] r_ortho [0:2];
    logic signed [RW-1:0] r_norm  [0:2];
    logic signed [RW-1:0] r_o_alpha, r_o_beta, r_o_gamma;
    logic                 r_o_degen;

    // Saturate a wide signed value to the result width
    function automatic logic signed [RW-1:0] sat_res(input logic signed [ptpf_pkg::VS_W-1:0] v);
        logic [ptpf_pkg::VS_W-RW:0] top;
        top = v[ptpf_pkg::VS_W-1:RW-1];
        if ((top == '0) || (top == '1)) begin
            sat_res = v[RW-1:0];
        end else if (v[ptpf_pkg::VS_W-1]) begin
            sat_res = {1'b1, {(RW-1){1'b0}}};
        end else begin
            sat_res = {1'b0, {(RW-1){1'b1}}};
        end
    endfunction

    assign busy = 1'b0;

    // Stage 1: edges
    assign w_p0 = {i_p0_z, i_p0_y, i_p0_x};
    assign w_p1 = {i_p1_z, i_p1_y, i_p1_x};
    assign w_p2 = {i_p2_z, i_p2_y, i_p2_x};
    assign w_p3 = {i_p3_z, i_p3_y, i_p3_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ed.e0[k] = ptpf_pkg::E_W'($signed(w_p1[k])) - ptpf_pkg::E_W'($signed(w_p2[k]));
            n_ed.e1[k] = ptpf_pkg::E_W'($signed(w_p3[k])) - ptpf_pkg::E_W'($signed(w_p2[k]));
            n_ed.e2[k] = ptpf_pkg::E_W'($signed(w_p0[k])) - ptpf_pkg::E_W'($signed(w_p2[k]));
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= PD; s++) r_vld[s] <= 1'b0;
        end else begin
            r_vld[1] <= start && !busy;
            for (int s = 2; s <= PD; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Edge carry chain
    always_ff @(posedge i_clk) begin
        r_ed[1] <= n_ed;
        for (int s = 2; s < PD; s++) r_ed[s] <= r_ed[s-1];
    end

    // Stages 2-3: component products, then dot sums
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_mp[ptpf_pkg::D_00][k] <= ptpf_pkg::PROD1_W'($signed(r_ed[1].e0[k]))
                                     * ptpf_pkg::PROD1_W'($signed(r_ed[1].e0[k]));
            r_mp[ptpf_pkg::D_01][k] <= ptpf_pkg::PROD1_W'($signed(r_ed[1].e0[k]))
                                     * ptpf_pkg::PROD1_W'($signed(r_ed[1].e1[k]));
            r_mp[ptpf_pkg::D_11][k] <= ptpf_pkg::PROD1_W'($signed(r_ed[1].e1[k]))
                                     * ptpf_pkg::PROD1_W'($signed(r_ed[1].e1[k]));
            r_mp[ptpf_pkg::D_B0][k] <= ptpf_pkg::PROD1_W'($signed(r_ed[1].e0[k]))
                                     * ptpf_pkg::PROD1_W'($signed(r_ed[1].e2[k]));
            r_mp[ptpf_pkg::D_B1][k] <= ptpf_pkg::PROD1_W'($signed(r_ed[1].e1[k]))
                                     * ptpf_pkg::PROD1_W'($signed(r_ed[1].e2[k]));
        end
        for (int j = 0; j < ptpf_pkg::DOT_N; j++) begin
            r_dot[j] <= ptpf_pkg::DOT_W'(r_mp[j][0]) + ptpf_pkg::DOT_W'(r_mp[j][1])
                      + ptpf_pkg::DOT_W'(r_mp[j][2]);
        end
    end

    // Stage 4: split wide products into four partial products each
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ptpf_pkg::WP_N; j++) begin
            r_pp_hh[j] <= ptpf_pkg::PP_W'($signed(
                              r_dot[ptpf_pkg::WP_A[j]][ptpf_pkg::DOT_W-1:ptpf_pkg::HALF_W]))
                        * ptpf_pkg::PP_W'($signed(
                              r_dot[ptpf_pkg::WP_B[j]][ptpf_pkg::DOT_W-1:ptpf_pkg::HALF_W]));
            r_pp_hl[j] <= ptpf_pkg::PP_W'($signed(
                              r_dot[ptpf_pkg::WP_A[j]][ptpf_pkg::DOT_W-1:ptpf_pkg::HALF_W]))
                        * ptpf_pkg::PP_W'($signed(
                              {1'b0, r_dot[ptpf_pkg::WP_B[j]][ptpf_pkg::HALF_W-1:0]}));
            r_pp_lh[j] <= ptpf_pkg::PP_W'($signed(
                              {1'b0, r_dot[ptpf_pkg::WP_A[j]][ptpf_pkg::HALF_W-1:0]}))
                        * ptpf_pkg::PP_W'($signed(
                              r_dot[ptpf_pkg::WP_B[j]][ptpf_pkg::DOT_W-1:ptpf_pkg::HALF_W]));
            r_pp_ll[j] <= ptpf_pkg::PP_W'($signed(
                              {1'b0, r_dot[ptpf_pkg::WP_A[j]][ptpf_pkg::HALF_W-1:0]}))
                        * ptpf_pkg::PP_W'($signed(
                              {1'b0, r_dot[ptpf_pkg::WP_B[j]][ptpf_pkg::HALF_W-1:0]}));
        end
        r_an4 <= r_dot[ptpf_pkg::D_01];
        r_ad4 <= r_dot[ptpf_pkg::D_00];
    end

    // Stage 5: recombine partial products
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ptpf_pkg::WP_N; j++) begin
            r_wp[j] <= (ptpf_pkg::PROD2_W'(r_pp_hh[j]) <<< (2 * ptpf_pkg::HALF_W))
                     + ((ptpf_pkg::PROD2_W'(r_pp_hl[j]) + ptpf_pkg::PROD2_W'(r_pp_lh[j]))
                        <<< ptpf_pkg::HALF_W)
                     + ptpf_pkg::PROD2_W'(r_pp_ll[j]);
        end
        r_an5 <= r_an4;
        r_ad5 <= r_ad4;
    end

    // Stage 6: determinant, Cramer numerators and the alpha lane operands
    always_ff @(posedge i_clk) begin
        r_num[ptpf_pkg::LANE_ALPHA] <= ptpf_pkg::NUM_W'(r_an5);
        r_den[ptpf_pkg::LANE_ALPHA] <= ptpf_pkg::NUM_W'(r_ad5);
        r_num[ptpf_pkg::LANE_BETA]  <= ptpf_pkg::NUM_W'(r_wp[2]) - ptpf_pkg::NUM_W'(r_wp[3]);
        r_den[ptpf_pkg::LANE_BETA]  <= ptpf_pkg::NUM_W'(r_wp[0]) - ptpf_pkg::NUM_W'(r_wp[1]);
        r_num[ptpf_pkg::LANE_GAMMA] <= ptpf_pkg::NUM_W'(r_wp[4]) - ptpf_pkg::NUM_W'(r_wp[5]);
        r_den[ptpf_pkg::LANE_GAMMA] <= ptpf_pkg::NUM_W'(r_wp[0]) - ptpf_pkg::NUM_W'(r_wp[1]);
    end

    // Stage 7: magnitudes, signs, overflow precheck (quotient of 2^RW or more)
    always_comb begin
        n_sd.degen = (r_den[ptpf_pkg::LANE_BETA] == '0);
        for (int l = 0; l < ptpf_pkg::LANE_N; l++) begin
            n_sd.neg[l] = r_num[l][ptpf_pkg::NUM_W-1] ^ r_den[l][ptpf_pkg::NUM_W-1];
            n_dm[l]     = r_den[l][ptpf_pkg::NUM_W-1] ? ptpf_pkg::NUM_W'(-r_den[l])
                                                      : ptpf_pkg::NUM_W'(r_den[l]);
            n_rem[l]    = ptpf_pkg::SH_W'(r_num[l][ptpf_pkg::NUM_W-1]
                                          ? ptpf_pkg::NUM_W'(-r_num[l])
                                          : ptpf_pkg::NUM_W'(r_num[l])) << ptpf_pkg::FRAC_BITS;
            n_sd.ovf[l] = ptpf_pkg::CMP_W'(n_rem[l]) >= (ptpf_pkg::CMP_W'(n_dm[l]) << RW);
        end
    end

    // Divider steps: stage s resolves quotient bit RW-s
    always_comb begin
        for (int s = 1; s <= DV; s++) begin
            for (int l = 0; l < ptpf_pkg::LANE_N; l++) begin
                w_dsub[s][l] = ptpf_pkg::CMP_W'(r_rem[s-1][l])
                             - (ptpf_pkg::CMP_W'(r_dm[s-1][l]) << (RW - s));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= n_sd;
        for (int l = 0; l < ptpf_pkg::LANE_N; l++) begin
            r_rem[0][l] <= n_rem[l];
            r_dm[0][l]  <= n_dm[l];
            r_q[0][l]   <= '0;
        end
        for (int s = 1; s <= DV; s++) begin
            r_sd[s] <= r_sd[s-1];
            for (int l = 0; l < ptpf_pkg::LANE_N; l++) begin
                r_dm[s][l] <= r_dm[s-1][l];
                r_q[s][l]  <= {r_q[s-1][l][RW-2:0], !w_dsub[s][l][ptpf_pkg::CMP_W-1]};
                r_rem[s][l] <= w_dsub[s][l][ptpf_pkg::CMP_W-1]
                             ? r_rem[s-1][l] : w_dsub[s][l][ptpf_pkg::SH_W-1:0];
            end
        end
    end

    // Ratio stage: saturation, sign, degenerate zeroing
    always_comb begin
        logic [RW-1:0] lim;
        logic [RW-1:0] mag;
        for (int l = 0; l < ptpf_pkg::LANE_N; l++) begin
            lim = r_sd[DV].neg[l] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
            mag = (r_sd[DV].ovf[l] || (r_q[DV][l] > lim)) ? lim : r_q[DV][l];
            if (r_sd[DV].degen) begin
                n_rat[l] = '0;
            end else begin
                n_rat[l] = r_sd[DV].neg[l] ? -mag : mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < ptpf_pkg::LANE_N; l++) r_rat[l] <= n_rat[l];
        r_dg_r <= r_sd[DV].degen;
    end

    // Vector product stage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_pa[k] <= ptpf_pkg::VP_W'(r_rat[ptpf_pkg::LANE_ALPHA])
                     * ptpf_pkg::VP_W'($signed(r_ed[PD-2].e0[k]));
            r_pb[k] <= ptpf_pkg::VP_W'(r_rat[ptpf_pkg::LANE_BETA])
                     * ptpf_pkg::VP_W'($signed(r_ed[PD-2].e0[k]));
            r_pg[k] <= ptpf_pkg::VP_W'(r_rat[ptpf_pkg::LANE_GAMMA])
                     * ptpf_pkg::VP_W'($signed(r_ed[PD-2].e1[k]));
        end
        for (int l = 0; l < ptpf_pkg::LANE_N; l++) r_rat2[l] <= r_rat[l];
        r_dg_p <= r_dg_r;
    end

    // Output stage: frame columns, floor shift, saturate
    always_comb begin
        logic signed [ptpf_pkg::VS_W-1:0] so;
        logic signed [ptpf_pkg::VS_W-1:0] sn;
        for (int k = 0; k < 3; k++) begin
            so = (ptpf_pkg::VS_W'($signed(r_ed[PD-1].e1[k])) <<< ptpf_pkg::FRAC_BITS)
               - ptpf_pkg::VS_W'(r_pa[k]);
            sn = (ptpf_pkg::VS_W'($signed(r_ed[PD-1].e2[k])) <<< ptpf_pkg::FRAC_BITS)
               - ptpf_pkg::VS_W'(r_pb[k]) - ptpf_pkg::VS_W'(r_pg[k]);
            n_ortho[k] = r_dg_p ? '0 : sat_res(so >>> ptpf_pkg::FRAC_BITS);
            n_norm[k]  = r_dg_p ? '0 : sat_res(sn >>> ptpf_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ortho[k] <= n_ortho[k];
            r_norm[k]  <= n_norm[k];
        end
        r_o_alpha <= r_rat2[ptpf_pkg::LANE_ALPHA];
        r_o_beta  <= r_rat2[ptpf_pkg::LANE_BETA];
        r_o_gamma <= r_rat2[ptpf_pkg::LANE_GAMMA];
        r_o_degen <= r_dg_p;
    end

    assign o_valid         = r_vld[PD];
    assign o_alpha_ratio   = r_o_alpha;
    assign o_beta_coord    = r_o_beta;
    assign o_gamma_coord   = r_o_gamma;
    assign o_ortho_edge_x  = r_ortho[0];
    assign o_ortho_edge_y  = r_ortho[1];
    assign o_ortho_edge_z  = r_ortho[2];
    assign o_normal_part_x = r_norm[0];
    assign o_normal_part_y = r_norm[1];
    assign o_normal_part_z = r_norm[2];
    assign o_degenerate    = r_o_degen;

    // Every started query returns exactly one beat after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PD o_valid)
        else $error("query beat missing at fixed latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PD))
        else $error("result beat without a started query");

    // Degenerate beats carry zeros in all three ratios, ortho_edge_x and normal_part_z
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_alpha_ratio == '0) && (o_beta_coord == '0) && (o_gamma_coord == '0)
            && (o_ortho_edge_x == '0) && (o_normal_part_z == '0))
        else $error("degenerate beat with nonzero fields");

    // A zero-denominator alpha lane always lands in the degenerate case
    a_alpha_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dm[0][ptpf_pkg::LANE_ALPHA] == '0) |-> r_sd[0].degen)
        else $error("zero e0 not flagged degenerate");

endmodule

`default_nettype wire
